FILE: design/vr_pkg.sv
// shared types and fixed widths for the vector reflection pipeline
package vr_pkg;

  localparam int W     = 32;  // component width
  localparam int SUMW  = 64;  // sum of squares width
  localparam int ROOTW = 32;  // normal length width
  localparam int REMW  = 34;  // partial remainder width in sqrt and divide cells
  localparam int DW    = 35;  // truncated dot product width
  localparam int NSQ   = SUMW / 2;  // sqrt cells, one root bit each

  // item data that travels alongside the arithmetic
  typedef struct packed {
    logic [2:0][W-1:0] a;     // incident vector
    logic [2:0]        nsg;   // sign of each normal component
    logic [2:0][W-1:0] nmag;  // magnitude of each normal component
    logic              zero;  // normal is all zero
  } side_t;

  // one result beat
  typedef struct packed {
    logic [2:0][W-1:0] v;
    logic              zero;
    logic              sat;
  } res_t;

endpackage

FILE: design/vr_sqrt_cell.sv
// one step of the digit-by-digit floor square root, one root bit per cell
module vr_sqrt_cell
  import vr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              i_valid,
  input  side_t             i_side,
  input  logic [SUMW-1:0]   i_rad,
  input  logic [REMW-1:0]   i_rem,
  input  logic [ROOTW-1:0]  i_root,
  output logic              o_valid,
  output side_t             o_side,
  output logic [SUMW-1:0]   o_rad,
  output logic [REMW-1:0]   o_rem,
  output logic [ROOTW-1:0]  o_root
);

  logic [REMW+1:0] rem_sh;
  logic [REMW+1:0] trial;
  logic            ge;
  logic [REMW+1:0] rem_sub;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh  = {i_rem, i_rad[SUMW-1 -: 2]};
    trial   = {2'b00, i_root, 2'b01};
    ge      = (rem_sh >= trial);
    rem_sub = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_side <= i_side;
      o_rad  <= {i_rad[SUMW-3:0], 2'b00};
      o_rem  <= ge ? rem_sub[REMW-1:0] : rem_sh[REMW-1:0];
      o_root <= {i_root[ROOTW-2:0], ge};
    end
  end

endmodule

FILE: design/vr_div_cell.sv
// one restoring divide step for all three normal components, one quotient bit per cell
module vr_div_cell
  import vr_pkg::*;
#(
  parameter int QB = 17
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  i_valid,
  input  side_t                 i_side,
  input  logic [ROOTW-1:0]      i_len,
  input  logic [2:0][REMW-1:0]  i_rem,
  input  logic [2:0]            i_low,
  input  logic [2:0][QB-1:0]    i_q,
  output logic                  o_valid,
  output side_t                 o_side,
  output logic [ROOTW-1:0]      o_len,
  output logic [2:0][REMW-1:0]  o_rem,
  output logic [2:0]            o_low,
  output logic [2:0][QB-1:0]    o_q
);

  logic [2:0][REMW:0]   rem_sh;
  logic [2:0][REMW:0]   rem_sub;
  logic [2:0]           ge;
  logic [2:0][REMW-1:0] rem_n;
  logic [2:0][QB-1:0]   q_n;

  // shift in the next dividend bit and subtract the length where it fits
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rem_sh[k]  = {i_rem[k], i_low[k]};
      ge[k]      = (rem_sh[k] >= {{(REMW+1-ROOTW){1'b0}}, i_len});
      rem_sub[k] = rem_sh[k] - {{(REMW+1-ROOTW){1'b0}}, i_len};
      rem_n[k]   = ge[k] ? rem_sub[k][REMW-1:0] : rem_sh[k][REMW-1:0];
      q_n[k]     = {i_q[k][QB-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_side <= i_side;
      o_len  <= i_len;
      o_rem  <= rem_n;
      o_low  <= 3'b000;
      o_q    <= q_n;
    end
  end

endmodule

FILE: design/vector_reflect.sv
// top level: reflection of an incident vector about a normal, fully pipelined
//
//   channel | signals                                         | direction
//   input   | in_valid, in_ready, in_x..z, normal_x..z        | in
//   output  | out_valid, out_ready, out_x..z, zero_normal,    | out
//           | saturated                                       |
//
// one beat accepted per cycle while the skid register is empty; a beat passes
// the front stages, the square root cell row (one root bit per cell), the divide
// cell row (one quotient bit per cell), the back end stages and the output register.
// reset clears all valid bits; there is no clearing pass.
// an output stall fills a one-beat skid register; the whole pipeline then
// holds until the skid register drains.
module vector_reflect
  import vr_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [W-1:0] in_x,
  input  logic signed [W-1:0] in_y,
  input  logic signed [W-1:0] in_z,
  input  logic signed [W-1:0] normal_x,
  input  logic signed [W-1:0] normal_y,
  input  logic signed [W-1:0] normal_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [W-1:0] out_x,
  output logic signed [W-1:0] out_y,
  output logic signed [W-1:0] out_z,
  output logic                zero_normal,
  output logic                saturated
);

  localparam int QB  = FRAC_BITS + 1;        // quotient bits, |u| <= 1.0
  localparam int UW  = QB + 1;               // signed unit normal width
  localparam int PW  = W + UW;               // incident times unit product
  localparam int SW  = PW + 2;               // dot sum
  localparam int RW  = DW + UW;              // dot times unit product
  localparam int TW  = 36;                   // truncated projection
  localparam int XW  = TW + 1;               // difference before clamp
  localparam logic [SW-1:0] DBIAS = SW'((1 << FRAC_BITS) - 1);
  localparam logic [RW:0]   PBIAS = (RW+1)'((1 << FRAC_BITS) - 1);
  localparam logic signed [XW-1:0] MAXV = XW'(64'sd2147483647);
  localparam logic signed [XW-1:0] MINV = XW'(-64'sd2147483648);

  logic en;
  logic skid_valid;

  assign en       = !skid_valid;
  assign in_ready = en;

  // front: magnitudes and squares of the normal
  logic [2:0][W-1:0] in_a;
  logic [2:0][W-1:0] in_n;
  side_t             side_in;

  always_comb begin
    in_a = {in_z, in_y, in_x};
    in_n = {normal_z, normal_y, normal_x};
    side_in.a = in_a;
    for (int k = 0; k < 3; k++) begin
      side_in.nsg[k]  = in_n[k][W-1];
      side_in.nmag[k] = in_n[k][W-1] ? (~in_n[k] + W'(1)) : in_n[k];
    end
    side_in.zero = (in_n == '0);
  end

  logic                 v0;
  side_t                side0;
  logic [2:0][SUMW-1:0] sq0;
  logic                 v1;
  side_t                side1;
  logic [SUMW-1:0]      sum1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side0 <= side_in;
      for (int k = 0; k < 3; k++) begin
        sq0[k] <= SUMW'(side_in.nmag[k]) * SUMW'(side_in.nmag[k]);
      end
      side1 <= side0;
      sum1  <= sq0[0] + sq0[1] + sq0[2];
    end
  end

  // square root cell row
  logic [NSQ:0]              sv;
  side_t                     ss   [NSQ+1];
  logic [NSQ:0][SUMW-1:0]    srad;
  logic [NSQ:0][REMW-1:0]    srem;
  logic [NSQ:0][ROOTW-1:0]   sroot;

  assign sv[0]    = v1;
  assign ss[0]    = side1;
  assign srad[0]  = sum1;
  assign srem[0]  = '0;
  assign sroot[0] = '0;

  for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
    vr_sqrt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .i_valid (sv[i]),
      .i_side  (ss[i]),
      .i_rad   (srad[i]),
      .i_rem   (srem[i]),
      .i_root  (sroot[i]),
      .o_valid (sv[i+1]),
      .o_side  (ss[i+1]),
      .o_rad   (srad[i+1]),
      .o_rem   (srem[i+1]),
      .o_root  (sroot[i+1])
    );
  end

  // divide cell row
  logic [QB:0]              dv;
  side_t                    ds   [QB+1];
  logic [QB:0][ROOTW-1:0]   dlen;
  logic [2:0][REMW-1:0]     drem [QB+1];
  logic [QB:0][2:0]         dlow;
  logic [2:0][QB-1:0]       dq   [QB+1];

  always_comb begin
    dv[0]   = sv[NSQ];
    ds[0]   = ss[NSQ];
    dlen[0] = sroot[NSQ];
    for (int k = 0; k < 3; k++) begin
      drem[0][k] = REMW'(ss[NSQ].nmag[k][W-1:1]);
      dlow[0][k] = ss[NSQ].nmag[k][0];
      dq[0][k]   = '0;
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_div
    vr_div_cell #(.QB(QB)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .i_valid (dv[i]),
      .i_side  (ds[i]),
      .i_len   (dlen[i]),
      .i_rem   (drem[i]),
      .i_low   (dlow[i]),
      .i_q     (dq[i]),
      .o_valid (dv[i+1]),
      .o_side  (ds[i+1]),
      .o_len   (dlen[i+1]),
      .o_rem   (drem[i+1]),
      .o_low   (dlow[i+1]),
      .o_q     (dq[i+1])
    );
  end

  // signed unit normal
  logic signed [2:0][UW-1:0] u_in;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      u_in[k] = ds[QB].nsg[k] ? (~{1'b0, dq[QB][k]} + UW'(1)) : {1'b0, dq[QB][k]};
    end
  end

  // back end stage registers
  logic [6:1]                 ev;
  side_t                      es   [1:6];
  logic [2:0][UW-1:0]         eu   [1:4];
  logic [2:0][PW-1:0]         prod1;
  logic [SW-1:0]              dot2;
  logic [DW-1:0]              d3;
  logic [2:0][RW-1:0]         pr4;
  logic [2:0][TW-1:0]         p5;

  // combinational pieces of each back end stage
  logic [2:0][PW-1:0] prod_c;
  logic [SW-1:0]      dot_c;
  logic [SW-1:0]      dtr_c;
  logic [2:0][RW-1:0] pr_c;
  logic [2:0][RW:0]   pr2;
  logic [2:0][RW:0]   ptr_c;
  logic [2:0][XW-1:0] diff_c;
  res_t               fin_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_c[k] = PW'($signed(es[1].a[k][W-1] ? {{(PW-W){1'b1}}, es[1].a[k]}
                                             : {{(PW-W){1'b0}}, es[1].a[k]})
                      * $signed({{(PW-UW){eu[1][k][UW-1]}}, eu[1][k]}));
    end
    dot_c = {{2{prod1[0][PW-1]}}, prod1[0]} + {{2{prod1[1][PW-1]}}, prod1[1]}
          + {{2{prod1[2][PW-1]}}, prod1[2]};
    // truncate toward zero: bias negative values before the shift
    dtr_c = $signed(dot2[SW-1] ? (dot2 + DBIAS) : dot2) >>> FRAC_BITS;
    for (int k = 0; k < 3; k++) begin
      pr_c[k] = RW'($signed({{(RW-DW){d3[DW-1]}}, d3})
                    * $signed({{(RW-UW){eu[4][k][UW-1]}}, eu[4][k]}));
      pr2[k]  = {pr4[k], 1'b0};
      ptr_c[k] = $signed(pr4[k][RW-1] ? (pr2[k] + PBIAS) : pr2[k]) >>> FRAC_BITS;
      diff_c[k] = $signed({es[6].a[k][W-1], {(XW-W-1){es[6].a[k][W-1]}}, es[6].a[k]})
                - $signed({p5[k][TW-1], p5[k]});
    end
    // clamp, flag, and zero-normal pass-through
    fin_c.zero = es[6].zero;
    fin_c.sat  = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (es[6].zero) begin
        fin_c.v[k] = es[6].a[k];
      end else if ($signed(diff_c[k]) > MAXV) begin
        fin_c.v[k] = MAXV[W-1:0];
        fin_c.sat  = 1'b1;
      end else if ($signed(diff_c[k]) < MINV) begin
        fin_c.v[k] = MINV[W-1:0];
        fin_c.sat  = 1'b1;
      end else begin
        fin_c.v[k] = diff_c[k][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev <= '0;
    end else if (en) begin
      ev <= {ev[5:1], dv[QB]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      es[1] <= ds[QB];
      eu[1] <= u_in;
      for (int s = 2; s <= 6; s++) begin
        es[s] <= es[s-1];
      end
      for (int s = 2; s <= 4; s++) begin
        eu[s] <= eu[s-1];
      end
      prod1 <= prod_c;
      dot2  <= dot_c;
      d3    <= dtr_c[DW-1:0];
      pr4   <= pr_c;
      for (int k = 0; k < 3; k++) begin
        p5[k] <= ptr_c[k][TW-1:0];
      end
    end
  end

  // output register and skid register
  res_t outr;
  res_t skid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (ev[6]) begin
      if (out_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        outr <= skid;
      end
    end else if (ev[6]) begin
      if (out_valid && !out_ready) begin
        skid <= fin_c;
      end else begin
        outr <= fin_c;
      end
    end
  end

  assign out_x       = outr.v[0];
  assign out_y       = outr.v[1];
  assign out_z       = outr.v[2];
  assign zero_normal = outr.zero;
  assign saturated   = outr.sat;

`ifndef SYNTH
  // the skid register only fills behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid beat without output beat");

  // a skid beat is taken only when the output was stalled
  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid filled without a stall");

  // a zero normal passes the incident vector, never clamped
  a_zero_no_sat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_normal) |-> !saturated)
    else $error("zero normal beat flagged saturated");
`endif

endmodule
